### rtl/core/hrpc_pkg.sv
// ----------------------------------------------------------------------------
// hrpc_pkg: shared types and constants for the hour record parser
// Holds the parser phase and status codes, field lengths, the result word
// layout and the sizes of the id table and the result queue.
// ----------------------------------------------------------------------------
package hrpc_pkg;

  // Id table size and the widths that follow from it.
  localparam int unsigned MAX_VARIABLES = 16;
  localparam int unsigned VIDX_W        = $clog2(MAX_VARIABLES);
  localparam int unsigned VCNT_W        = $clog2(MAX_VARIABLES + 1);

  // Result queue depth; two entries must be free to accept a byte.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_IDX_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // Field widths of the record and of the results.
  localparam int unsigned MAX_SAMP_W = 20;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FLAGS_W    = 8;
  localparam int unsigned STATUS_W   = 3;

  localparam logic [MAX_SAMP_W-1:0] MAX_SAMP_RESET = MAX_SAMP_W'(3600);

  // Parser phase: which field the next byte belongs to.
  typedef enum logic [2:0] {
    PH_CSUM   = 3'd0,
    PH_HOUR   = 3'd1,
    PH_COUNT  = 3'd2,
    PH_FLAGS  = 3'd3,
    PH_SCOUNT = 3'd4,
    PH_VID    = 3'd5,
    PH_DATA   = 3'd6,
    PH_TAIL   = 3'd7
  } phase_e;

  // Record status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_BAD_COUNT = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_DUP_ID    = 3'd4,
    ST_TRAILING  = 3'd5,
    ST_CSUM      = 3'd6
  } status_e;

  // Result kind.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // One result word as it sits in the output queue.
  typedef struct packed {
    logic                  kind;
    logic [ID_W-1:0]       var_id;
    logic [MAX_SAMP_W-1:0] sample_index;
    logic [WORD_W-1:0]     sample_bits;
    status_e               status;
    logic [WORD_W-1:0]     hour_id;
    logic [FLAGS_W-1:0]    record_flags;
    logic [ID_W-1:0]       variables_seen;
    logic                  last_of_run;
  } res_t;

  // Number of bytes in the field of a phase.
  function automatic logic [2:0] field_len(phase_e ph);
    logic [2:0] len;
    unique case (ph)
      PH_CSUM, PH_HOUR, PH_SCOUNT, PH_DATA: len = 3'd4;
      PH_COUNT, PH_VID:                     len = 3'd2;
      PH_FLAGS, PH_TAIL:                    len = 3'd1;
      default:                              len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/hrpc_byte_if.sv
// ----------------------------------------------------------------------------
// hrpc_byte_if: record byte channel
// Valid/ready channel that carries one record byte and its last-byte marker.
// ----------------------------------------------------------------------------
interface hrpc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

### rtl/core/hrpc_res_if.sv
// ----------------------------------------------------------------------------
// hrpc_res_if: parser result channel
// Valid/ready channel that carries one sample word or one record status.
// ----------------------------------------------------------------------------
interface hrpc_res_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [hrpc_pkg::ID_W-1:0]       var_id;
  logic [hrpc_pkg::MAX_SAMP_W-1:0] sample_index;
  logic [hrpc_pkg::WORD_W-1:0]     sample_bits;
  logic [hrpc_pkg::STATUS_W-1:0]   status;
  logic [hrpc_pkg::WORD_W-1:0]     hour_id;
  logic [hrpc_pkg::FLAGS_W-1:0]    record_flags;
  logic [hrpc_pkg::ID_W-1:0]       variables_seen;
  logic                            last_of_run;

  modport source (
    output valid, output kind, output var_id, output sample_index,
    output sample_bits, output status, output hour_id, output record_flags,
    output variables_seen, output last_of_run, input ready
  );
  modport sink (
    input valid, input kind, input var_id, input sample_index,
    input sample_bits, input status, input hour_id, input record_flags,
    input variables_seen, input last_of_run, output ready
  );
endinterface

### rtl/core/hour_record_parse_check_core.sv
// ----------------------------------------------------------------------------
// hour_record_parse_check_core: streaming hour record parser and checker
// Assembles little-endian header and variable fields byte by byte, emits each
// sample word, checks counts, ids and the running checksum, and reports status.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while at least two of the four result queue
// entries are free; a byte that finishes a sample and ends the record yields
// two words, sample word first, both pushed into the queue together.
// Result words are registered in the queue and leave from its head.
// Reset: clears the parser to the start of a record, empties the queue and
// sets the sample limit to 3600; the id table is not cleared.
module hour_record_parse_check_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hrpc_pkg::MAX_SAMP_W-1:0] cfg_wdata_i,
  hrpc_byte_if.sink                       byte_i,
  hrpc_res_if.source                      res_o
);

  // Parser state.
  hrpc_pkg::phase_e                phase_q, phase_d;
  logic [1:0]                      fbc_q, fbc_d;
  logic [hrpc_pkg::WORD_W-1:0]     shift_q, shift_d;
  logic [hrpc_pkg::WORD_W-1:0]     csum_q, csum_d;
  logic [hrpc_pkg::WORD_W-1:0]     sum_q, sum_d;
  logic [hrpc_pkg::WORD_W-1:0]     hour_q, hour_d;
  logic [hrpc_pkg::ID_W-1:0]       decl_q, decl_d;
  logic [hrpc_pkg::VCNT_W-1:0]     vdone_q, vdone_d;
  logic [hrpc_pkg::FLAGS_W-1:0]    flags_q, flags_d;
  logic [hrpc_pkg::MAX_SAMP_W-1:0] samples_q, samples_d;
  logic [hrpc_pkg::ID_W-1:0]       cur_id_q, cur_id_d;
  logic [hrpc_pkg::MAX_SAMP_W-1:0] pos_q, pos_d;
  hrpc_pkg::status_e               err_q, err_d;
  logic [hrpc_pkg::MAX_SAMP_W-1:0] max_samp_q;
  logic [hrpc_pkg::WORD_W-1:0]     field_word;

  // Id table, written once per accepted variable, compared in parallel.
  logic [hrpc_pkg::ID_W-1:0] id_tab_q [hrpc_pkg::MAX_VARIABLES];
  logic                      id_wr;
  logic [hrpc_pkg::MAX_VARIABLES-1:0] id_hit;

  // Result queue.
  hrpc_pkg::res_t              rq_q [hrpc_pkg::RQ_DEPTH];
  logic [hrpc_pkg::RQ_CNT_W-1:0] rq_cnt_q, rq_cnt_d;
  hrpc_pkg::res_t              push0, push1;
  logic                        push0_v, push1_v;
  logic                        acc, pop;

  assign acc          = byte_i.valid && byte_i.ready;
  assign pop          = res_o.valid && res_o.ready;
  assign byte_i.ready = rq_cnt_q <= hrpc_pkg::RQ_CNT_W'(hrpc_pkg::RQ_DEPTH - 2);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_samp_q <= hrpc_pkg::MAX_SAMP_RESET;
    end else if (cfg_we_i) begin
      max_samp_q <= cfg_wdata_i;
    end
  end

  // Field word as it stands with the current byte merged in.
  always_comb begin
    field_word = shift_q;
    unique case (fbc_q)
      2'd0: field_word[7:0]   = byte_i.byte_value;
      2'd1: field_word[15:8]  = byte_i.byte_value;
      2'd2: field_word[23:16] = byte_i.byte_value;
      2'd3: field_word[31:24] = byte_i.byte_value;
      default: field_word = shift_q;
    endcase
  end

  // Duplicate id compare against the accepted entries.
  always_comb begin
    for (int i = 0; i < hrpc_pkg::MAX_VARIABLES; i++) begin
      id_hit[i] = (hrpc_pkg::VCNT_W'(i) < vdone_q) &&
                  (id_tab_q[i] == field_word[hrpc_pkg::ID_W-1:0]);
    end
  end

  // Next parser state and the result words of the accepted byte.
  always_comb begin
    logic [hrpc_pkg::WORD_W-1:0] v;
    logic                        done;
    logic                        emit;
    hrpc_pkg::status_e           fail_code;
    logic                        do_fail;
    hrpc_pkg::status_e           st;

    phase_d   = phase_q;
    fbc_d     = fbc_q;
    shift_d   = shift_q;
    csum_d    = csum_q;
    sum_d     = sum_q;
    hour_d    = hour_q;
    decl_d    = decl_q;
    vdone_d   = vdone_q;
    flags_d   = flags_q;
    samples_d = samples_q;
    cur_id_d  = cur_id_q;
    pos_d     = pos_q;
    err_d     = err_q;
    id_wr     = 1'b0;
    emit      = 1'b0;
    do_fail   = 1'b0;
    fail_code = hrpc_pkg::ST_OK;
    st        = hrpc_pkg::ST_OK;
    v         = field_word;
    done      = ({1'b0, fbc_q} + 3'd1) >= hrpc_pkg::field_len(phase_q);

    if (phase_q == hrpc_pkg::PH_TAIL) begin
      if (err_q == hrpc_pkg::ST_OK) begin
        err_d = hrpc_pkg::ST_TRAILING;
      end
    end else begin
      if (done) begin
        fbc_d   = 2'd0;
        shift_d = '0;
      end else begin
        fbc_d   = fbc_q + 2'd1;
        shift_d = v;
      end
      if (phase_q == hrpc_pkg::PH_DATA) begin
        sum_d = sum_q + {24'd0, byte_i.byte_value};
      end

      // Completed field handling.
      if (done) begin
        unique case (phase_q)
          hrpc_pkg::PH_CSUM: begin
            csum_d  = v;
            phase_d = hrpc_pkg::PH_HOUR;
          end
          hrpc_pkg::PH_HOUR: begin
            hour_d  = v;
            sum_d   = sum_q + v;
            phase_d = hrpc_pkg::PH_COUNT;
          end
          hrpc_pkg::PH_COUNT: begin
            decl_d  = v[hrpc_pkg::ID_W-1:0];
            sum_d   = sum_q + {16'd0, v[hrpc_pkg::ID_W-1:0]};
            phase_d = hrpc_pkg::PH_FLAGS;
          end
          hrpc_pkg::PH_FLAGS: begin
            flags_d = v[hrpc_pkg::FLAGS_W-1:0];
            sum_d   = sum_q + {24'd0, v[hrpc_pkg::FLAGS_W-1:0]};
            phase_d = ({11'd0, vdone_q} >= decl_q) ? hrpc_pkg::PH_TAIL
                                                   : hrpc_pkg::PH_SCOUNT;
          end
          hrpc_pkg::PH_SCOUNT: begin
            samples_d = (v > {12'd0, max_samp_q}) ? '0 : v[hrpc_pkg::MAX_SAMP_W-1:0];
            phase_d   = hrpc_pkg::PH_VID;
          end
          hrpc_pkg::PH_VID: begin
            cur_id_d = v[hrpc_pkg::ID_W-1:0];
            priority if (samples_q == '0) begin
              do_fail   = 1'b1;
              fail_code = hrpc_pkg::ST_BAD_COUNT;
            end else if (vdone_q >= hrpc_pkg::VCNT_W'(hrpc_pkg::MAX_VARIABLES)) begin
              do_fail   = 1'b1;
              fail_code = hrpc_pkg::ST_TOO_MANY;
            end else if (|id_hit) begin
              do_fail   = 1'b1;
              fail_code = hrpc_pkg::ST_DUP_ID;
            end else begin
              id_wr   = 1'b1;
              vdone_d = vdone_q + 1'b1;
              sum_d   = sum_q + {16'd0, v[hrpc_pkg::ID_W-1:0]} + {12'd0, samples_q};
              pos_d   = '0;
              phase_d = hrpc_pkg::PH_DATA;
            end
          end
          hrpc_pkg::PH_DATA: begin
            emit  = 1'b1;
            pos_d = pos_q + 1'b1;
            if ((pos_q + 1'b1) >= samples_q) begin
              phase_d = ({11'd0, vdone_q} >= decl_q) ? hrpc_pkg::PH_TAIL
                                                     : hrpc_pkg::PH_SCOUNT;
            end
          end
          hrpc_pkg::PH_TAIL: begin
            phase_d = hrpc_pkg::PH_TAIL;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end

      // The record ends before it is complete.
      if (!do_fail && byte_i.last_byte && phase_d != hrpc_pkg::PH_TAIL) begin
        do_fail   = 1'b1;
        fail_code = hrpc_pkg::ST_TRUNC;
      end
      if (do_fail) begin
        phase_d = hrpc_pkg::PH_TAIL;
        if (err_q == hrpc_pkg::ST_OK) begin
          err_d = fail_code;
        end
      end
    end

    // Final status of the record.
    st = err_d;
    if (st == hrpc_pkg::ST_OK && sum_d != csum_d) begin
      st = hrpc_pkg::ST_CSUM;
    end

    // Sample word.
    push0.kind           = hrpc_pkg::KIND_SAMPLE;
    push0.var_id         = cur_id_q;
    push0.sample_index   = pos_q;
    push0.sample_bits    = v;
    push0.status         = hrpc_pkg::ST_OK;
    push0.hour_id        = hour_d;
    push0.record_flags   = flags_d;
    push0.variables_seen = decl_d;
    push0.last_of_run    = !byte_i.last_byte;

    // Status word.
    push1.kind           = hrpc_pkg::KIND_STATUS;
    push1.var_id         = '0;
    push1.sample_index   = '0;
    push1.sample_bits    = '0;
    push1.status         = st;
    push1.hour_id        = hour_d;
    push1.record_flags   = flags_d;
    push1.variables_seen = decl_d;
    push1.last_of_run    = 1'b1;

    // A sample word goes first; a lone status moves into the first slot.
    if (!emit) begin
      push0 = push1;
    end
    push0_v = acc && (emit || byte_i.last_byte);
    push1_v = acc && emit && byte_i.last_byte;

    // Start over after the last byte.
    if (byte_i.last_byte) begin
      phase_d   = hrpc_pkg::PH_CSUM;
      fbc_d     = '0;
      shift_d   = '0;
      csum_d    = '0;
      sum_d     = '0;
      hour_d    = '0;
      decl_d    = '0;
      vdone_d   = '0;
      flags_d   = '0;
      samples_d = '0;
      cur_id_d  = '0;
      pos_d     = '0;
      err_d     = hrpc_pkg::ST_OK;
    end
  end

  // Parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= hrpc_pkg::PH_CSUM;
      fbc_q     <= '0;
      shift_q   <= '0;
      csum_q    <= '0;
      sum_q     <= '0;
      hour_q    <= '0;
      decl_q    <= '0;
      vdone_q   <= '0;
      flags_q   <= '0;
      samples_q <= '0;
      cur_id_q  <= '0;
      pos_q     <= '0;
      err_q     <= hrpc_pkg::ST_OK;
    end else if (acc) begin
      phase_q   <= phase_d;
      fbc_q     <= fbc_d;
      shift_q   <= shift_d;
      csum_q    <= csum_d;
      sum_q     <= sum_d;
      hour_q    <= hour_d;
      decl_q    <= decl_d;
      vdone_q   <= vdone_d;
      flags_q   <= flags_d;
      samples_q <= samples_d;
      cur_id_q  <= cur_id_d;
      pos_q     <= pos_d;
      err_q     <= err_d;
    end
  end

  // Id table write at the next free slot.
  always_ff @(posedge clk_i) begin
    if (acc && id_wr) begin
      id_tab_q[vdone_q[hrpc_pkg::VIDX_W-1:0]] <= field_word[hrpc_pkg::ID_W-1:0];
    end
  end

  // Result queue: the head sits in entry zero and the rest shift down on a pop.
  logic [hrpc_pkg::RQ_CNT_W-1:0] rq_base;
  assign rq_base  = rq_cnt_q - hrpc_pkg::RQ_CNT_W'(pop);
  assign rq_cnt_d = rq_base + hrpc_pkg::RQ_CNT_W'(push0_v) + hrpc_pkg::RQ_CNT_W'(push1_v);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < hrpc_pkg::RQ_DEPTH; i++) begin
      if (push0_v && hrpc_pkg::RQ_CNT_W'(i) == rq_base) begin
        rq_q[i] <= push0;
      end else if (push1_v && hrpc_pkg::RQ_CNT_W'(i) == rq_base + 1'b1) begin
        rq_q[i] <= push1;
      end else if (pop && i < hrpc_pkg::RQ_DEPTH - 1) begin
        rq_q[i] <= rq_q[(i + 1) % hrpc_pkg::RQ_DEPTH];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_cnt_q <= '0;
    end else begin
      rq_cnt_q <= rq_cnt_d;
    end
  end

  // Output word from the queue head.
  assign res_o.valid          = rq_cnt_q != '0;
  assign res_o.kind           = rq_q[0].kind;
  assign res_o.var_id         = rq_q[0].var_id;
  assign res_o.sample_index   = rq_q[0].sample_index;
  assign res_o.sample_bits    = rq_q[0].sample_bits;
  assign res_o.status         = rq_q[0].status;
  assign res_o.hour_id        = rq_q[0].hour_id;
  assign res_o.record_flags   = rq_q[0].record_flags;
  assign res_o.variables_seen = rq_q[0].variables_seen;
  assign res_o.last_of_run    = rq_q[0].last_of_run;

  // Checks.
  a_rq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= hrpc_pkg::RQ_CNT_W'(hrpc_pkg::RQ_DEPTH))
    else $error("result queue overflow");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && byte_i.last_byte) |=> (phase_q == hrpc_pkg::PH_CSUM && fbc_q == 2'd0 &&
                                   vdone_q == '0))
    else $error("parser did not restart after the last byte");

  a_vdone_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vdone_q <= hrpc_pkg::VCNT_W'(hrpc_pkg::MAX_VARIABLES))
    else $error("variable count beyond id table");

  a_tail_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && phase_q == hrpc_pkg::PH_TAIL && !byte_i.last_byte) |=>
      rq_cnt_q <= $past(rq_cnt_q))
    else $error("word emitted for a trailing byte");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hrpc_pkg::PH_DATA) |-> (pos_q < samples_q))
    else $error("sample index beyond sample count");

endmodule

### tb/hour_record_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hour_record_checker: result predictor and scoreboard for the record parser
// Watches the byte and result channels and the sample limit writes. It parses
// every accepted byte with its own copy of the record state, queues the words
// that the byte should produce, and compares each accepted result word with
// the oldest queued word.
// ----------------------------------------------------------------------------
module hour_record_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hrpc_pkg::MAX_SAMP_W-1:0] cfg_wdata_i,
  hrpc_byte_if                            byte_i,
  hrpc_res_if                             res_i,
  output int                              mismatch_count_o,
  output int                              words_pending_o
);

  // Sample limit as last written.
  logic [hrpc_pkg::MAX_SAMP_W-1:0] samp_limit;

  // Parse state of the record in flight.
  hrpc_pkg::phase_e                parse_phase;
  int unsigned                     field_pos;
  logic [hrpc_pkg::WORD_W-1:0]     field_acc;
  logic [hrpc_pkg::WORD_W-1:0]     stored_csum;
  logic [hrpc_pkg::WORD_W-1:0]     running_sum;
  logic [hrpc_pkg::WORD_W-1:0]     hour_val;
  logic [hrpc_pkg::ID_W-1:0]       declared_vars;
  logic [hrpc_pkg::ID_W-1:0]       vars_accepted;
  logic [hrpc_pkg::FLAGS_W-1:0]    flags_val;
  logic [hrpc_pkg::MAX_SAMP_W-1:0] cur_count;
  logic [hrpc_pkg::ID_W-1:0]       cur_id;
  logic [hrpc_pkg::MAX_SAMP_W-1:0] sample_pos;
  logic [hrpc_pkg::ID_W-1:0]       accepted_ids [hrpc_pkg::MAX_VARIABLES];
  hrpc_pkg::status_e               first_err;

  // Words still owed by the block, oldest first.
  hrpc_pkg::res_t expected_words[$];
  int             mismatches = 0;
  int             pending_words = 0;

  assign mismatch_count_o = mismatches;
  assign words_pending_o  = pending_words;

  // Number of bytes that make up the field of a phase.
  function automatic int unsigned field_bytes(hrpc_pkg::phase_e ph);
    case (ph)
      hrpc_pkg::PH_COUNT, hrpc_pkg::PH_VID: return 2;
      hrpc_pkg::PH_CSUM, hrpc_pkg::PH_HOUR,
      hrpc_pkg::PH_SCOUNT, hrpc_pkg::PH_DATA: return 4;
      default:                                return 1;
    endcase
  endfunction

  function automatic string describe_word(hrpc_pkg::res_t w);
    return {$sformatf("kind=%0d id=%h idx=%0d bits=%h status=%0d ", w.kind, w.var_id,
                      w.sample_index, w.sample_bits, w.status),
            $sformatf("hour=%h flags=%h vars=%0d last=%0d", w.hour_id, w.record_flags,
                      w.variables_seen, w.last_of_run)};
  endfunction

  // Result word built from the current header state.
  function automatic hrpc_pkg::res_t make_word(
    logic kind, logic [hrpc_pkg::ID_W-1:0] vid, logic [hrpc_pkg::MAX_SAMP_W-1:0] idx,
    logic [hrpc_pkg::WORD_W-1:0] bits, hrpc_pkg::status_e st, logic last);
    hrpc_pkg::res_t w;
    w.kind           = kind;
    w.var_id         = vid;
    w.sample_index   = idx;
    w.sample_bits    = bits;
    w.status         = st;
    w.hour_id        = hour_val;
    w.record_flags   = flags_val;
    w.variables_seen = declared_vars;
    w.last_of_run    = last;
    return w;
  endfunction

  task automatic start_record();
    parse_phase   = hrpc_pkg::PH_CSUM;
    field_pos     = 0;
    field_acc     = '0;
    stored_csum   = '0;
    running_sum   = '0;
    hour_val      = '0;
    declared_vars = '0;
    vars_accepted = '0;
    flags_val     = '0;
    cur_count     = '0;
    cur_id        = '0;
    sample_pos    = '0;
    first_err     = hrpc_pkg::ST_OK;
  endtask

  // Only the first error of a record is kept; the rest of it is skipped.
  task automatic record_error(hrpc_pkg::status_e code);
    if (first_err == hrpc_pkg::ST_OK) begin
      first_err = code;
    end
    parse_phase = hrpc_pkg::PH_TAIL;
  endtask

  task automatic next_variable();
    if (vars_accepted >= declared_vars) begin
      parse_phase = hrpc_pkg::PH_TAIL;
    end else begin
      parse_phase = hrpc_pkg::PH_SCOUNT;
    end
  endtask

  // Acts on a completed field; a data field yields one sample word.
  task automatic finish_field(input logic [hrpc_pkg::WORD_W-1:0] v,
                              output logic got_sample,
                              output hrpc_pkg::res_t sample_word);
    logic dup;
    got_sample  = 1'b0;
    sample_word = '0;
    dup         = 1'b0;
    case (parse_phase)
      hrpc_pkg::PH_CSUM: begin
        stored_csum = v;
        parse_phase = hrpc_pkg::PH_HOUR;
      end
      hrpc_pkg::PH_HOUR: begin
        hour_val    = v;
        running_sum = running_sum + v;
        parse_phase = hrpc_pkg::PH_COUNT;
      end
      hrpc_pkg::PH_COUNT: begin
        declared_vars = v[hrpc_pkg::ID_W-1:0];
        running_sum   = running_sum + hrpc_pkg::WORD_W'(declared_vars);
        parse_phase   = hrpc_pkg::PH_FLAGS;
      end
      hrpc_pkg::PH_FLAGS: begin
        flags_val   = v[hrpc_pkg::FLAGS_W-1:0];
        running_sum = running_sum + hrpc_pkg::WORD_W'(flags_val);
        next_variable();
      end
      hrpc_pkg::PH_SCOUNT: begin
        // An oversized count is held as zero so the count check at the id field rejects it.
        cur_count   = (v > hrpc_pkg::WORD_W'(samp_limit)) ? '0
                                                          : v[hrpc_pkg::MAX_SAMP_W-1:0];
        parse_phase = hrpc_pkg::PH_VID;
      end
      hrpc_pkg::PH_VID: begin
        cur_id = v[hrpc_pkg::ID_W-1:0];
        for (int i = 0; i < int'(vars_accepted) && i < hrpc_pkg::MAX_VARIABLES; i++) begin
          if (accepted_ids[i] == cur_id) begin
            dup = 1'b1;
          end
        end
        if (cur_count == '0) begin
          record_error(hrpc_pkg::ST_BAD_COUNT);
        end else if (vars_accepted >= hrpc_pkg::MAX_VARIABLES) begin
          record_error(hrpc_pkg::ST_TOO_MANY);
        end else if (dup) begin
          record_error(hrpc_pkg::ST_DUP_ID);
        end else begin
          accepted_ids[vars_accepted[hrpc_pkg::VIDX_W-1:0]] = cur_id;
          vars_accepted = vars_accepted + 1'b1;
          running_sum   = running_sum + hrpc_pkg::WORD_W'(cur_id) +
                          hrpc_pkg::WORD_W'(cur_count);
          sample_pos    = '0;
          parse_phase   = hrpc_pkg::PH_DATA;
        end
      end
      hrpc_pkg::PH_DATA: begin
        got_sample  = 1'b1;
        sample_word = make_word(hrpc_pkg::KIND_SAMPLE, cur_id, sample_pos, v,
                                hrpc_pkg::ST_OK, 1'b0);
        sample_pos  = sample_pos + 1'b1;
        if (sample_pos >= cur_count) begin
          next_variable();
        end
      end
      default: begin
      end
    endcase
  endtask

  // Parses one accepted byte and queues the words it should cause.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic                        got_sample;
    hrpc_pkg::res_t              sample_word;
    hrpc_pkg::status_e           final_st;
    logic [hrpc_pkg::WORD_W-1:0] v;
    got_sample  = 1'b0;
    sample_word = '0;
    if (parse_phase == hrpc_pkg::PH_TAIL) begin
      if (first_err == hrpc_pkg::ST_OK) begin
        first_err = hrpc_pkg::ST_TRAILING;
      end
    end else begin
      field_acc = field_acc | (hrpc_pkg::WORD_W'(b) << (8 * field_pos));
      if (parse_phase == hrpc_pkg::PH_DATA) begin
        running_sum = running_sum + hrpc_pkg::WORD_W'(b);
      end
      if (field_pos + 1 >= field_bytes(parse_phase)) begin
        v         = field_acc;
        field_pos = 0;
        field_acc = '0;
        finish_field(v, got_sample, sample_word);
      end else begin
        field_pos++;
      end
      if (last && parse_phase != hrpc_pkg::PH_TAIL) begin
        record_error(hrpc_pkg::ST_TRUNC);
      end
    end
    // A byte that ends a sample and the record gives the sample first.
    if (got_sample) begin
      sample_word.last_of_run = !last;
      expected_words.push_back(sample_word);
    end
    if (last) begin
      final_st = first_err;
      if (final_st == hrpc_pkg::ST_OK && running_sum != stored_csum) begin
        final_st = hrpc_pkg::ST_CSUM;
      end
      expected_words.push_back(make_word(hrpc_pkg::KIND_STATUS, '0, '0, '0, final_st, 1'b1));
      start_record();
    end
  endtask

  // Compares one accepted result word with the oldest expected word.
  task automatic check_word();
    hrpc_pkg::res_t actual;
    hrpc_pkg::res_t wanted;
    actual.kind           = res_i.kind;
    actual.var_id         = res_i.var_id;
    actual.sample_index   = res_i.sample_index;
    actual.sample_bits    = res_i.sample_bits;
    actual.status         = hrpc_pkg::status_e'(res_i.status);
    actual.hour_id        = res_i.hour_id;
    actual.record_flags   = res_i.record_flags;
    actual.variables_seen = res_i.variables_seen;
    actual.last_of_run    = res_i.last_of_run;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result word: %s", describe_word(actual));
      end
    end else begin
      wanted = expected_words.pop_front();
      if (actual !== wanted) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result word mismatch");
          $display("  expected %s", describe_word(wanted));
          $display("  actual   %s", describe_word(actual));
        end
      end
    end
  endtask

  // Limit writes, byte acceptance and result acceptance, all at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_limit = hrpc_pkg::MAX_SAMP_RESET;
      start_record();
      expected_words.delete();
      pending_words = 0;
    end else begin
      if (cfg_we_i) begin
        samp_limit = cfg_wdata_i;
      end
      if (byte_i.valid && byte_i.ready) begin
        parse_byte(byte_i.byte_value, byte_i.last_byte);
      end
      if (res_i.valid && res_i.ready) begin
        check_word();
      end
      pending_words = expected_words.size();
    end
  end

endmodule

### tb/tb_hour_record_parse_check_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hour_record_parse_check_core: testbench for the hour record parser
// Feeds short directed records and then random records (well-formed ones,
// and ones with a bad checksum, truncation, trailing bytes, bad sample counts,
// duplicate ids, too many variables, or pure noise) under four sample limits.
// The sender idles in bursts and the receiver stalls on its own pattern,
// including one long hold-off. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_hour_record_parse_check_core;

  localparam int LIMIT_CYCLES    = 500000;
  localparam int BYTES_PER_PHASE = 350;
  localparam int RX_HOLD_AT      = 1500;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 4;

  // Sample limit of each random phase, both extremes among them.
  localparam logic [hrpc_pkg::MAX_SAMP_W-1:0] PHASE_LIMITS [4] = '{
    20'hFFFFF, 20'd1, 20'd5, 20'd3600
  };

  // Shapes of generated records.
  typedef enum int {
    REC_GOOD,
    REC_BAD_CSUM,
    REC_TRUNC,
    REC_TRAILING,
    REC_BAD_COUNT,
    REC_DUP_ID,
    REC_TOO_MANY,
    REC_NOISE
  } rec_kind_e;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [hrpc_pkg::MAX_SAMP_W-1:0] cfg_wdata;
  int                              mismatch_count;
  int                              words_pending;

  int                              cycle_count = 0;
  int                              sent_bytes = 0;
  int                              burst_left = 0;
  logic [hrpc_pkg::MAX_SAMP_W-1:0] cur_limit = hrpc_pkg::MAX_SAMP_RESET;
  logic [7:0]                      rec_bytes[$];

  hrpc_byte_if byte_ch ();
  hrpc_res_if  res_ch ();

  hour_record_parse_check_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .byte_i      (byte_ch),
    .res_o       (res_ch)
  );

  hour_record_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .byte_i           (byte_ch),
    .res_i            (res_ch),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_hour_record_parse_check_core NOT OK");
      $finish;
    end
  end

  // Receiver: changing ready patterns, with one long hold-off so the result
  // queue fills and the block stops taking bytes.
  initial begin
    int rx_cycles;
    int pattern_left;
    int ready_pct;
    rx_cycles    = 0;
    pattern_left = 0;
    ready_pct    = 100;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (rx_cycles == RX_HOLD_AT) begin
        res_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(8, 64);
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 80;
            2:       ready_pct = 40;
            default: ready_pct = 15;
          endcase
        end
        pattern_left--;
        res_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Appends a little-endian field to the record being built.
  task automatic put_le(input logic [31:0] value, input int nbytes);
    for (int k = 0; k < nbytes; k++) begin
      rec_bytes.push_back(value[8*k +: 8]);
    end
  endtask

  // Offers one byte and waits until it is taken; bursts end in random gaps.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.byte_value <= b;
    byte_ch.last_byte  <= last;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    burst_left--;
    sent_bytes++;
  endtask

  task automatic send_record();
    foreach (rec_bytes[k]) begin
      push_byte(rec_bytes[k], k == rec_bytes.size() - 1);
    end
  endtask

  // Waits until every expected word is out and the block is quiet.
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [hrpc_pkg::MAX_SAMP_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_limit = value;
  endtask

  function automatic rec_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return REC_GOOD;
    if (r < 63) return REC_BAD_CSUM;
    if (r < 71) return REC_TRUNC;
    if (r < 78) return REC_TRAILING;
    if (r < 85) return REC_BAD_COUNT;
    if (r < 92) return REC_DUP_ID;
    if (r < 94) return REC_TOO_MANY;
    return REC_NOISE;
  endfunction

  // Builds one record; the checksum is right unless the kind asks otherwise.
  task automatic build_record(input rec_kind_e kind);
    logic [7:0]  body[$];
    logic [15:0] ids[$];
    logic [15:0] id;
    logic [31:0] hour;
    logic [31:0] cnt;
    logic [31:0] csum;
    logic [31:0] word;
    logic [7:0]  flags;
    logic        taken;
    int          nvars;
    int          bad_var;
    int          dup_var;
    int          nsamp;
    int          cut;
    rec_bytes.delete();
    if (kind == REC_NOISE) begin
      repeat ($urandom_range(1, 20)) rec_bytes.push_back(8'($urandom));
      return;
    end
    nvars = (kind == REC_TOO_MANY) ? hrpc_pkg::MAX_VARIABLES + 1 : $urandom_range(0, 4);
    if ((kind == REC_BAD_COUNT && nvars < 1) || (kind == REC_DUP_ID && nvars < 2)) begin
      nvars = 2;
    end
    bad_var = $urandom_range(0, nvars - 1);
    dup_var = $urandom_range(1, nvars - 1);
    hour    = $urandom;
    flags   = 8'($urandom);
    csum    = hour + 32'(nvars) + 32'(flags);
    put_le(hour, 4);
    put_le(32'(nvars), 2);
    put_le(32'(flags), 1);
    for (int v = 0; v < nvars; v++) begin
      if (kind == REC_BAD_COUNT && v == bad_var) begin
        case ($urandom_range(0, 2))
          0:       cnt = '0;
          1:       cnt = 32'(cur_limit) + 1 + $urandom_range(0, 40);
          default: cnt = $urandom | 32'h8000_0000;
        endcase
        nsamp = $urandom_range(0, 2);
      end else begin
        if (kind == REC_TOO_MANY) begin
          cnt = 1;
        end else if (cur_limit <= 8 && $urandom_range(0, 2) == 0) begin
          cnt = 32'(cur_limit);
        end else begin
          cnt = $urandom_range(1, (cur_limit < 6) ? cur_limit : 6);
        end
        nsamp = int'(cnt);
      end
      // Ids are distinct except where a duplicate is wanted.
      if (kind == REC_DUP_ID && v == dup_var) begin
        id = ids[$urandom_range(0, v - 1)];
      end else begin
        do begin
          id    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
          taken = 1'b0;
          foreach (ids[k]) begin
            if (ids[k] == id) taken = 1'b1;
          end
        end while (taken);
      end
      ids.push_back(id);
      put_le(cnt, 4);
      put_le(32'(id), 2);
      csum = csum + 32'(id) + cnt;
      for (int s = 0; s < nsamp; s++) begin
        case ($urandom_range(0, 9))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom;
        endcase
        put_le(word, 4);
        csum = csum + 32'(word[7:0]) + 32'(word[15:8]) + 32'(word[23:16]) +
               32'(word[31:24]);
      end
    end
    if (kind == REC_BAD_CSUM) begin
      csum = csum ^ (32'd1 << $urandom_range(0, 31));
    end
    // The checksum leads the record.
    body = rec_bytes;
    rec_bytes.delete();
    put_le(csum, 4);
    foreach (body[k]) rec_bytes.push_back(body[k]);
    if (kind == REC_TRUNC) begin
      cut = $urandom_range(1, rec_bytes.size() - 1);
      while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
    end else if (kind == REC_TRAILING) begin
      repeat ($urandom_range(1, 3)) rec_bytes.push_back(8'($urandom));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    byte_ch.valid      <= 1'b0;
    byte_ch.byte_value <= '0;
    byte_ch.last_byte  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A lone byte that ends the record at once: truncated.
    rec_bytes.delete();
    rec_bytes.push_back(8'hA5);
    send_record();

    // Empty record with all-ones hour and flags, under the reset limit.
    rec_bytes.delete();
    put_le(32'h0000_00FE, 4);
    put_le(32'hFFFF_FFFF, 4);
    put_le(32'h0, 2);
    put_le(32'hFF, 1);
    send_record();

    // One variable, one all-ones sample; the last byte yields two words.
    rec_bytes.delete();
    put_le(32'h0001_03FD, 4);
    put_le(32'h0, 4);
    put_le(32'h1, 2);
    put_le(32'h0, 1);
    put_le(32'h1, 4);
    put_le(32'hFFFF, 2);
    put_le(32'hFFFF_FFFF, 4);
    send_record();

    // Random records, one sample limit per phase.
    for (int p = 0; p < 4; p++) begin
      write_limit(PHASE_LIMITS[p]);
      if (p == 1) begin
        build_record(REC_TOO_MANY);
        send_record();
      end
      while (sent_bytes < (p + 1) * BYTES_PER_PHASE) begin
        build_record(pick_kind());
        send_record();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_hour_record_parse_check_core OK");
    end else begin
      $display("tb_hour_record_parse_check_core NOT OK");
    end
    $finish;
  end

endmodule
